FILE: rtl/core/puct_child_select_top_macros.svh
// ----------------------------------------------------------------------------
// puct_child_select_top_macros
// assertion macros used by the rtl of the puct child select back end
// ----------------------------------------------------------------------------
`ifndef PUCT_CHILD_SELECT_TOP_MACROS_SVH
`define PUCT_CHILD_SELECT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PCS_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("pcs assertion failed");
`define PCS_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("pcs assertion failed");
`else
`define PCS_ASSERT_IMP(lbl, a, c)
`define PCS_ASSERT_NEXT(lbl, a, c)
`endif
`endif

FILE: rtl/core/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// types and constants of the puct child select block
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int MaxChildrenDefault = 512;
  localparam int SqrtSteps = 16;
  localparam int DivSteps = 29;

  localparam logic [15:0] GainReset = 16'd4096;
  localparam logic [16:0] NoiseMixReset = 17'd16384;
  localparam logic [16:0] EpsOne = 17'd65536;

  localparam logic RegExploreGain = 1'b0;
  localparam logic RegNoiseMix = 1'b1;

  typedef struct packed {
    logic [13:0]        action;
    logic [15:0]        mix;
    logic [19:0]        visits;
    logic signed [15:0] q;
    logic [19:0]        pvis;
    logic               last;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_MUL1, ST_MULLO, ST_MULHI, ST_DINIT, ST_DIV, ST_UPD
  } back_state_t;

endpackage

FILE: rtl/core/pcs_front.sv
// ----------------------------------------------------------------------------
// pcs_front
// accepts children, forms the noise mixed prior and the effective q and n
// ----------------------------------------------------------------------------
module pcs_front
  import pcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [13:0]        action_id,
  input  logic [15:0]        prior,
  input  logic [19:0]        child_visits,
  input  logic signed [15:0] child_value,
  input  logic               child_expanded,
  input  logic [15:0]        noise_value,
  input  logic               use_noise,
  input  logic [19:0]        parent_visits,
  input  logic signed [15:0] parent_value,
  input  logic               last_child,
  input  logic [16:0]        eps,
  input  logic               q_full,
  output logic               q_push,
  output item_t              q_item
);

  logic               st_v;
  logic [13:0]        st_action;
  logic [32:0]        st_pn;
  logic [32:0]        st_pp;
  logic               st_use;
  logic [15:0]        st_prior;
  logic [19:0]        st_n;
  logic signed [15:0] st_q;
  logic [19:0]        st_pvis;
  logic               st_last;
  logic               accept;
  logic [16:0]        eps_inv;
  logic [32:0]        mix_sum;

  assign full    = st_v && q_full;
  assign accept  = push && !full;
  assign q_push  = st_v && !q_full;
  assign eps_inv = EpsOne - eps;
  assign mix_sum = st_pn + st_pp + 33'd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v <= 1'b0;
    end else if (accept) begin
      st_v <= 1'b1;
    end else if (q_push) begin
      st_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_action <= action_id;
      st_pn     <= 33'(eps) * 33'(noise_value);
      st_pp     <= 33'(eps_inv) * 33'(prior);
      st_use    <= use_noise;
      st_prior  <= prior;
      st_n      <= child_expanded ? child_visits : 20'd0;
      st_q      <= child_expanded ? child_value : parent_value;
      st_pvis   <= parent_visits;
      st_last   <= last_child;
    end
  end

  always_comb begin
    q_item.action = st_action;
    q_item.mix    = st_use ? mix_sum[31:16] : st_prior;
    q_item.visits = st_n;
    q_item.q      = st_q;
    q_item.pvis   = st_pvis;
    q_item.last   = st_last;
  end

endmodule

FILE: rtl/core/pcs_fifo.sv
// ----------------------------------------------------------------------------
// pcs_fifo
// two entry queue between the front and the scoring back end
// ----------------------------------------------------------------------------
module pcs_fifo
  import pcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wr_item,
  output logic  q_full,
  input  logic  rd,
  output logic  q_valid,
  output item_t rd_item
);

  item_t      mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign q_full  = count == 2'd2;
  assign q_valid = count != 2'd0;
  assign rd_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      if (wr && !rd) begin
        count <= count + 2'd1;
      end else if (rd && !wr) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wr_item;
    end
  end

endmodule

FILE: rtl/core/pcs_back.sv
// ----------------------------------------------------------------------------
// pcs_back
// square root, exploration product, division and running maximum
// ----------------------------------------------------------------------------
`include "puct_child_select_top_macros.svh"
module pcs_back
  import pcs_pkg::*;
#(
  parameter int MAX_CHILDREN = MaxChildrenDefault
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  input  logic [15:0]        gain,
  output logic               out_v,
  input  logic               pop,
  output logic [13:0]        out_action,
  output logic [8:0]         out_position,
  output logic signed [31:0] out_score
);

  localparam int PW = $clog2(MAX_CHILDREN);

  back_state_t        state;
  back_state_t        state_next;
  item_t              cur;
  logic [31:0]        sq_x;
  logic [19:0]        sq_rem;
  logic [15:0]        sq_root;
  logic [4:0]         cnt;
  logic [31:0]        p1;
  logic [47:0]        num;
  logic [20:0]        dv_rem;
  logic [28:0]        dv_quo;
  logic               run_open;
  logic [PW-1:0]      pos;
  logic signed [31:0] best_score;
  logic [13:0]        best_action;
  logic [8:0]         best_position;
  logic [19:0]        rem_sh;
  logic [19:0]        trial;
  logic [20:0]        divisor;
  logic [21:0]        rs;
  logic signed [31:0] score;
  logic               take;
  logic [PW-1:0]      pos_used;
  logic [PW+8:0]      pos_wide;
  logic               stall;
  logic               emit;
  logic               step_done;

  assign rem_sh   = {sq_rem[17:0], sq_x[31:30]};
  assign trial    = {2'b00, sq_root, 2'b01};
  assign divisor  = {1'b0, cur.visits} + 21'd1;
  assign rs       = {dv_rem, dv_quo[28]};
  assign score    = {{16{cur.q[15]}}, cur.q} + {3'b000, dv_quo};
  assign take     = !run_open || (score > best_score);
  assign pos_used = run_open ? pos : '0;
  assign pos_wide = {9'd0, pos_used};
  assign stall    = cur.last && out_v && !pop;
  assign emit     = state == ST_UPD && !stall && cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    step_done  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (cnt == 5'(SqrtSteps - 1)) begin
          state_next = ST_MUL1;
        end
      end
      ST_MUL1:  state_next = ST_MULLO;
      ST_MULLO: state_next = ST_MULHI;
      ST_MULHI: state_next = ST_DINIT;
      ST_DINIT: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == 5'(DivSteps - 1)) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        if (!stall) begin
          step_done  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur     <= q_item;
        sq_x    <= {q_item.pvis, 12'd0};
        sq_rem  <= '0;
        sq_root <= '0;
        cnt     <= '0;
      end
      ST_SQRT: begin
        if (rem_sh >= trial) begin
          sq_rem  <= rem_sh - trial;
          sq_root <= {sq_root[14:0], 1'b1};
        end else begin
          sq_rem  <= rem_sh;
          sq_root <= {sq_root[14:0], 1'b0};
        end
        sq_x <= {sq_x[29:0], 2'b00};
        cnt  <= cnt + 5'd1;
      end
      ST_MUL1:  p1  <= 32'(gain) * 32'(cur.mix);
      ST_MULLO: num <= {16'd0, 32'(p1[15:0]) * 32'(sq_root)};
      ST_MULHI: num <= num + {32'(p1[31:16]) * 32'(sq_root), 16'd0};
      ST_DINIT: begin
        dv_quo <= num[47:19];
        dv_rem <= '0;
        cnt    <= '0;
      end
      ST_DIV: begin
        if (rs >= {1'b0, divisor}) begin
          dv_rem <= 21'(rs - {1'b0, divisor});
          dv_quo <= {dv_quo[27:0], 1'b1};
        end else begin
          dv_rem <= rs[20:0];
          dv_quo <= {dv_quo[27:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
      end
      ST_UPD: begin
      end
      default: begin
      end
    endcase
  end

  // running maximum and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_open      <= 1'b0;
      pos           <= '0;
      best_score    <= '0;
      best_action   <= '0;
      best_position <= '0;
      out_v         <= 1'b0;
    end else begin
      if (step_done) begin
        if (take) begin
          best_score    <= score;
          best_action   <= cur.action;
          best_position <= pos_wide[8:0];
        end
        run_open <= !cur.last;
        if (cur.last || pos_used == PW'(MAX_CHILDREN - 1)) begin
          pos <= '0;
        end else begin
          pos <= pos_used + PW'(1);
        end
      end
      if (emit) begin
        out_v <= 1'b1;
      end else if (pop) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_action   <= take ? cur.action : best_action;
      out_position <= take ? pos_wide[8:0] : best_position;
      out_score    <= take ? score : best_score;
    end
  end

  `PCS_ASSERT_IMP(a_emit_free, emit, !out_v || pop)
  `PCS_ASSERT_NEXT(a_div_to_upd, state == ST_DIV && cnt == 5'(DivSteps - 1), state == ST_UPD)
  `PCS_ASSERT_NEXT(a_stall_holds, state == ST_UPD && stall, state == ST_UPD)

endmodule

FILE: rtl/core/puct_child_select_top.sv
// ----------------------------------------------------------------------------
// puct_child_select_top
// puct score of each child and running maximum, winner on the last child
//
// channel   dir  handshake           payload
// input     in   push / full         action_id .. last_child
// result    out  pop / empty         chosen_action, chosen_position, chosen_score
// config    in   cfg_write           cfg_index, cfg_data
//
// the back end scores one child at a time: 16 square root steps, the gain, low and high
// multiply steps, a divider set-up, 29 divider steps and an update
// the front mixes the prior in one register stage; a two entry queue decouples it
// reset is synchronous; the back end stalls only when a winner is ready
// while the previous one has not been popped
// ----------------------------------------------------------------------------
module puct_child_select_top
  import pcs_pkg::*;
#(
  parameter int MAX_CHILDREN = MaxChildrenDefault
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [13:0]        action_id,
  input  logic [15:0]        prior,
  input  logic [19:0]        child_visits,
  input  logic signed [15:0] child_value,
  input  logic               child_expanded,
  input  logic [15:0]        noise_value,
  input  logic               use_noise,
  input  logic [19:0]        parent_visits,
  input  logic signed [15:0] parent_value,
  input  logic               last_child,
  output logic               empty,
  input  logic               pop,
  output logic [13:0]        chosen_action,
  output logic [8:0]         chosen_position,
  output logic signed [31:0] chosen_score
);

  logic [15:0] explore_gain;
  logic [16:0] noise_mix;
  logic [16:0] eps;
  logic        q_full;
  logic        q_push;
  item_t       q_wr_item;
  logic        q_valid;
  logic        q_pop;
  item_t       q_rd_item;
  logic        out_v;

  assign eps   = (noise_mix > EpsOne) ? EpsOne : noise_mix;
  assign empty = !out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      explore_gain <= GainReset;
      noise_mix    <= NoiseMixReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegExploreGain: explore_gain <= cfg_data[15:0];
        RegNoiseMix:    noise_mix    <= cfg_data;
      endcase
    end
  end

  pcs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .action_id      (action_id),
    .prior          (prior),
    .child_visits   (child_visits),
    .child_value    (child_value),
    .child_expanded (child_expanded),
    .noise_value    (noise_value),
    .use_noise      (use_noise),
    .parent_visits  (parent_visits),
    .parent_value   (parent_value),
    .last_child     (last_child),
    .eps            (eps),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_wr_item)
  );

  pcs_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_item (q_wr_item),
    .q_full  (q_full),
    .rd      (q_pop),
    .q_valid (q_valid),
    .rd_item (q_rd_item)
  );

  pcs_back #(
    .MAX_CHILDREN (MAX_CHILDREN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_rd_item),
    .q_pop        (q_pop),
    .gain         (explore_gain),
    .out_v        (out_v),
    .pop          (pop),
    .out_action   (chosen_action),
    .out_position (chosen_position),
    .out_score    (chosen_score)
  );

endmodule

FILE: tb/sv/puct_child_select_top_tb.sv
// ----------------------------------------------------------------------------
// puct_child_select_top_tb
// self-checking testbench of the puct child select block
//
// children are streamed through the push / full side, with random gaps in busy mode; a
// cycle-free predictor computes the puct score of every accepted child and
// keeps the running winner, and each popped winner is compared with the
// oldest predicted one. covers field extremes, register extremes, long runs
// with position wrap, back pressure and a long random mix of runs
// ----------------------------------------------------------------------------
module puct_child_select_top_tb;
  import pcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HalfPeriod = 6;
  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 200;
  localparam int MaxKids = MaxChildrenDefault;

  typedef struct {
    logic [13:0]        action_id;
    logic [15:0]        prior;
    logic [19:0]        child_visits;
    logic signed [15:0] child_value;
    logic               child_expanded;
    logic [15:0]        noise_value;
    logic               use_noise;
    logic [19:0]        parent_visits;
    logic signed [15:0] parent_value;
    logic               last_child;
  } child_t;

  typedef struct {
    logic [13:0]        action;
    logic [8:0]         position;
    logic signed [31:0] score;
  } winner_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic               cfg_index = RegExploreGain;
  logic [16:0]        cfg_data = '0;
  logic               push = 1'b0;
  logic               full;
  logic [13:0]        action_id = '0;
  logic [15:0]        prior = '0;
  logic [19:0]        child_visits = '0;
  logic signed [15:0] child_value = '0;
  logic               child_expanded = 1'b0;
  logic [15:0]        noise_value = '0;
  logic               use_noise = 1'b0;
  logic [19:0]        parent_visits = '0;
  logic signed [15:0] parent_value = '0;
  logic               last_child = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [13:0]        chosen_action;
  logic [8:0]         chosen_position;
  logic signed [31:0] chosen_score;

  puct_child_select_top uut (.*);

  always begin
    #HalfPeriod clk = 1'b1;
    #HalfPeriod clk = 1'b0;
  end

  // predictor state
  logic [15:0]    gain_reg = GainReset;
  logic [16:0]    eps_reg = NoiseMixReset;
  longint         best_score = 0;
  logic [13:0]    best_action = '0;
  int             best_pos = 0;
  int             pos_count = 0;
  bit             run_open = 0;
  winner_t        winner_q[$];

  int  mismatches = 0;
  int  kids_sent = 0;
  int  winners_seen = 0;
  int  cycles = 0;
  bit  busy_mode = 1;
  bit  hold_on = 0;
  int  stall = 0;
  int  pick;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void score_child(child_t c);
    longint unsigned eps, mix, n, root, num, den;
    longint          q, score;
    winner_t         w;
    eps = (eps_reg > EpsOne) ? EpsOne : eps_reg;
    root = int_sqrt(longint'(c.parent_visits) << 12) & 64'hFFFF;
    if (c.use_noise) mix = (eps * c.noise_value + (65536 - eps) * c.prior + 32768) >> 16;
    else mix = c.prior;
    n = c.child_expanded ? c.child_visits : 0;
    q = c.child_expanded ? longint'(c.child_value) : longint'(c.parent_value);
    num = longint'(gain_reg) * mix * root;
    den = (1 + n) << 19;
    score = q + longint'(num / den);
    if (!run_open) pos_count = 0;
    if (!run_open || score > best_score) begin
      best_score = score;
      best_action = c.action_id;
      best_pos = pos_count;
    end
    run_open = 1;
    pos_count = (pos_count + 1 >= MaxKids) ? 0 : pos_count + 1;
    if (c.last_child) begin
      w.action = best_action;
      w.position = best_pos[8:0];
      w.score = best_score[31:0];
      winner_q.insert(winner_q.size(), w);
      run_open = 0;
      pos_count = 0;
    end
  endfunction

  function automatic child_t rand_child(bit last);
    child_t c;
    c.action_id = 14'($urandom);
    c.prior = 16'($urandom);
    c.child_visits = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 20));
    c.child_value = 16'($urandom);
    c.child_expanded = 1'($urandom);
    c.noise_value = 16'($urandom);
    c.use_noise = 1'($urandom);
    c.parent_visits = ($urandom_range(0, 1) == 0) ? 20'($urandom) : 20'($urandom_range(0, 400));
    c.parent_value = 16'($urandom);
    c.last_child = last;
    return c;
  endfunction

  task automatic send_child(child_t c);
    int gap;
    gap = busy_mode ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    action_id <= c.action_id;
    prior <= c.prior;
    child_visits <= c.child_visits;
    child_value <= c.child_value;
    child_expanded <= c.child_expanded;
    noise_value <= c.noise_value;
    use_noise <= c.use_noise;
    parent_visits <= c.parent_visits;
    parent_value <= c.parent_value;
    last_child <= c.last_child;
    @(posedge clk);
    while (full) @(posedge clk);
    score_child(c);
    kids_sent++;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (winner_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [16:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == RegExploreGain) gain_reg = data[15:0];
    else eps_reg = data;
  endtask

  task automatic send_run(int len);
    for (int i = 0; i < len; i++) send_child(rand_child(i == len - 1));
  endtask

  task automatic test_directed();
    child_t c;
    c = rand_child(1);
    // all fields at maximum, single child run
    c.action_id = '1; c.prior = '1; c.child_visits = '1; c.child_value = 16'sh7fff;
    c.child_expanded = 1; c.noise_value = '1; c.use_noise = 1; c.parent_visits = '1;
    c.parent_value = 16'sh7fff;
    send_child(c);
    // all fields at zero
    c.action_id = 0; c.prior = 0; c.child_visits = 0; c.child_value = 0; c.child_expanded = 0;
    c.noise_value = 0; c.use_noise = 0; c.parent_visits = 0; c.parent_value = 0;
    send_child(c);
    // most negative values, unexpanded child ignores its visits and value
    c.child_value = 16'sh8000; c.parent_value = 16'sh8000; c.child_visits = '1;
    c.prior = '1; c.parent_visits = '1;
    send_child(c);
    c.child_expanded = 1; c.child_visits = 0; c.child_value = 16'sh8000;
    c.parent_value = 16'sh7fff;
    send_child(c);
    // ties keep the earlier child
    c = rand_child(0);
    c.action_id = 14'd5;
    send_child(c);
    c.action_id = 14'd6;
    send_child(c);
    c.action_id = 14'd7; c.last_child = 1;
    send_child(c);
    // later strictly greater wins, noise on and off
    for (int i = 0; i < 6; i++) begin
      c = rand_child(i == 5);
      c.child_expanded = 1; c.child_visits = 0; c.child_value = 16'(i * 1000);
      c.use_noise = i[0]; c.prior = 16'(i * 9000);
      send_child(c);
    end
    for (int i = 0; i < 8; i++) send_child(rand_child(i[1]));
    send_child(rand_child(1));
    wait_idle();
  endtask

  task automatic test_register_extremes();
    logic [15:0] gains[4] = '{16'd0, 16'd65535, 16'd1, 16'd4096};
    logic [16:0] epss[4] = '{17'd0, 17'd65536, 17'd131071, 17'd32768};
    for (int i = 0; i < 4; i++) begin
      write_reg(RegExploreGain, {1'b0, gains[i]});
      write_reg(RegNoiseMix, epss[i]);
      for (int r = 0; r < 4; r++) send_run($urandom_range(1, 5));
      wait_idle();
    end
  endtask

  task automatic test_position_wrap();
    busy_mode = 0;
    send_run(MaxKids + 20);
    busy_mode = 1;
    wait_idle();
  endtask

  task automatic test_back_pressure();
    fork
      begin
        hold_on <= 1'b1;
        repeat (1500) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    busy_mode = 0;
    for (int i = 0; i < 30; i++) send_run(1);
    busy_mode = 1;
    wait_idle();
  endtask

  task automatic test_random(int total);
    int done, len;
    done = 0;
    while (done < total) begin
      if ($urandom_range(0, 5) == 0) begin
        wait_idle();
        write_reg(RegExploreGain, 17'($urandom_range(0, 65535)));
        write_reg(RegNoiseMix, 17'($urandom_range(0, 131071)));
        busy_mode = $urandom_range(0, 3) != 0;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_run(len);
      done += len;
    end
    wait_idle();
  endtask

  // result side: random stalls, long hold-off on request, checking
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
    if (rst) begin
      pop <= 1'b0;
      stall <= 0;
    end else begin
      if (pop && !empty) begin
        winners_seen <= winners_seen + 1;
        if (winner_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: action %0d pos %0d score %0d",
                     chosen_action, chosen_position, chosen_score);
        end else begin
          winner_t w;
          w = winner_q.pop_front();
          if (w.action !== chosen_action || w.position !== chosen_position ||
              w.score !== chosen_score) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp action %0d pos %0d score %0d, got %0d %0d %0d",
                       w.action, w.position, w.score,
                       chosen_action, chosen_position, chosen_score);
          end
        end
      end
      if (hold_on) begin
        pop <= 1'b0;
      end else if (pop && !empty) begin
        pick = busy_mode ? $urandom_range(0, 10) : 0;
        stall <= pick;
        pop <= (pick == 0);
      end else if (stall != 0) begin
        stall <= stall - 1;
        pop <= (stall == 1);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_position_wrap();
    test_back_pressure();
    test_random(200);
    wait_idle();
    $display("%0d children sent, %0d winners checked, %0d cycles", kids_sent,
             winners_seen, cycles);
    $display("covered field and register extremes, position wrap, back pressure, random runs");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
